// ===== sv/id_allocator_with_generation_assert.svh =====
// assertion macros for the id allocator
// expects clk and rst in the scope where a macro is used
`ifndef ID_ALLOCATOR_WITH_GENERATION_ASSERT_SVH
`define ID_ALLOCATOR_WITH_GENERATION_ASSERT_SVH
`ifndef SYNTH
// checked outside reset
`define IDAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define IDAG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IDAG_ASSERT(lbl, prop, msg)
`define IDAG_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== sv/idag_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and transaction types of the id allocator
// no dependencies
package idag_pkg;

  localparam int NUM_IDS_DEF       = 256;
  localparam int MAP_WORD_BITS_DEF = 64;
  localparam int GEN_W             = 16;

  localparam logic [GEN_W-1:0] GEN_MAX = 16'hFFFF;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED   = 2'd1;
  localparam logic [1:0] ST_INVALID     = 2'd2;
  localparam logic [1:0] ST_DOUBLE_FREE = 2'd3;

  localparam logic [1:0] LIFE_NEVER    = 2'd0;
  localparam logic [1:0] LIFE_DEPARTED = 2'd1;
  localparam logic [1:0] LIFE_LIVE     = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [11:0]      id_in;
    logic [GEN_W-1:0] query_generation;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [8:0]       id_out;
    logic [GEN_W-1:0] slot_generation;
    logic             is_allocated;
    logic [1:0]       life;
    logic [8:0]       live_total;
  } rsp_t;

endpackage

// ===== sv/id_allocator_with_generation.sv =====
`timescale 1ns / 1ps
// id allocator with per-slot generation counters, top level
// depends on idag_pkg, idag_ram, idag_first_zero and the assertion header
//
// requests enter on req (valid/ready) and each gives exactly one response on rsp.
// one request is worked on at a time; req_ready is high whenever no request is
// in flight, even while the previous response still waits on rsp.
// allocate: accept, a scan of the bitmap word by word, a generation
// read-modify-write step, then the response load. the search starts at
// the lowest word that may hold a free slot, so it is usually one word.
// free and query: address split, ram read, update, response load.
// an invalid id, a full pool or an unknown operation goes from accept
// straight to the response load.
// the bitmap and generation rams have registered read data; every
// transaction reads, then writes back before the next request is taken.
// reset clears the fsm, the live count and a high-water mark; ram entries at
// or above the high-water mark read as zero, so no clearing pass is needed and
// the block takes requests in the first cycle after reset.
// when rsp_ready is low the finished response is held, the next request can
// still be accepted, and its own response waits until the output is free.
module id_allocator_with_generation
  import idag_pkg::*;
#(
  parameter int NUM_IDS       = NUM_IDS_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

`include "id_allocator_with_generation_assert.svh"

  localparam int MAP_WORDS = (NUM_IDS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int SLOT_W    = $clog2(NUM_IDS);
  localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int CNT_W     = $clog2(NUM_IDS + 1);
  // slot to word index by reciprocal multiply, exact for every slot
  localparam int DIV_SH    = SLOT_W + BIT_W;
  localparam int RECIP     = ((1 << DIV_SH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int PROD_W    = 2 * SLOT_W + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_SCAN = 6'b000100,
    S_GEN  = 6'b001000,
    S_LOOK = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t state, state_next;

  // control registers
  logic [CNT_W-1:0]   live_count;
  logic [CNT_W-1:0]   hw;
  logic [WORD_AW-1:0] hint;

  // request and working registers
  logic [1:0]               op;
  logic [GEN_W-1:0]         qgen;
  logic [SLOT_W-1:0]        slot;
  logic [WORD_AW-1:0]       word_idx;
  logic [BIT_W-1:0]         bit_idx;
  logic [MAP_WORD_BITS-1:0] word_hold;
  rsp_t                     res;

  // ram ports
  logic                     map_we;
  logic [MAP_WORD_BITS-1:0] map_wdata;
  logic [WORD_AW-1:0]       map_raddr;
  logic [MAP_WORD_BITS-1:0] map_rdata;
  logic                     gen_we;
  logic [GEN_W-1:0]         gen_wdata;
  logic [SLOT_W-1:0]        gen_raddr;
  logic [GEN_W-1:0]         gen_rdata;

  logic                     accept;
  logic                     rsp_free;
  logic                     id_ok;
  logic                     pool_full;
  logic [SLOT_W-1:0]        id_m1;
  logic [PROD_W-1:0]        id_prod;
  logic [WORD_AW-1:0]       id_word;
  logic [CNT_W-1:0]         word_base;
  logic                     word_live;
  logic                     gen_live;
  logic [MAP_WORD_BITS-1:0] map_word;
  logic [MAP_WORD_BITS-1:0] bit_mask;
  logic                     used;
  logic [GEN_W-1:0]         gen_cur;
  logic [GEN_W-1:0]         gen_new;
  logic                     fz_found;
  logic [BIT_W-1:0]         fz_idx;
  logic [SLOT_W-1:0]        slot_found;
  logic [WORD_AW-1:0]       word_next;
  logic                     scan_last;
  logic                     is_acc_op;
  logic [1:0]               acc_status;
  rsp_t                     res_init;
  rsp_t                     rsp_load;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  assign id_ok     = (req.id_in != 12'd0) && (13'(req.id_in) <= 13'(NUM_IDS));
  assign pool_full = (live_count == CNT_W'(NUM_IDS));
  assign id_m1     = SLOT_W'(req.id_in - 12'd1);
  assign id_prod   = PROD_W'(id_m1) * PROD_W'(RECIP);
  assign id_word   = WORD_AW'(id_prod >> DIV_SH);
  assign is_acc_op = (req.operation == OP_FREE) || (req.operation == OP_QUERY);

  // status known at accept time: full pool or bad id
  assign acc_status = (req.operation == OP_ALLOC && pool_full) ? ST_EXHAUSTED :
                      (is_acc_op && !id_ok)                    ? ST_INVALID   : ST_OK;

  always_comb begin
    res_init        = '0;
    res_init.status = acc_status;
  end

  always_comb begin
    rsp_load            = res;
    rsp_load.live_total = 9'(live_count);
  end

  // entries at or above the high-water mark were never written and read as zero
  assign word_base = CNT_W'(word_idx * MAP_WORD_BITS);
  assign word_live = word_base < hw;
  assign gen_live  = CNT_W'(slot) < hw;
  assign map_word  = word_live ? map_rdata : '0;
  assign gen_cur   = gen_live ? gen_rdata : '0;
  assign gen_new   = (gen_cur == GEN_MAX) ? GEN_W'(1) : gen_cur + GEN_W'(1);
  assign bit_mask  = MAP_WORD_BITS'(1) << bit_idx;
  assign used      = map_word[bit_idx];

  assign slot_found = SLOT_W'(word_base) + SLOT_W'(fz_idx);
  assign word_next  = word_idx + WORD_AW'(1);
  assign scan_last  = (word_idx == WORD_AW'(MAP_WORDS - 1));

  idag_first_zero #(
    .W (MAP_WORD_BITS)
  ) u_fz (
    .word  (map_word),
    .found (fz_found),
    .index (fz_idx)
  );

  idag_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (word_idx),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  idag_ram #(
    .WIDTH (GEN_W),
    .DEPTH (NUM_IDS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (slot),
    .wdata (gen_wdata),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  // ram addressing; writes land before the next transaction reads, so no forwarding
  always_comb begin
    map_raddr = word_idx;
    gen_raddr = slot;
    map_we    = 1'b0;
    map_wdata = map_word & ~bit_mask;
    gen_we    = 1'b0;
    gen_wdata = gen_new;
    case (state)
      S_IDLE: begin
        map_raddr = hint;
      end
      S_SCAN: begin
        map_raddr = word_next;
        gen_raddr = slot_found;
      end
      S_LOOK: begin
        map_we = (op == OP_FREE) && used;
      end
      S_GEN: begin
        map_we    = 1'b1;
        map_wdata = word_hold | bit_mask;
        gen_we    = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.operation == OP_ALLOC) begin
            state_next = pool_full ? S_RESP : S_SCAN;
          end else if (is_acc_op) begin
            state_next = id_ok ? S_PREP : S_RESP;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_PREP: state_next = S_LOOK;
      S_LOOK: state_next = S_RESP;
      S_SCAN: begin
        if (fz_found) begin
          state_next = S_GEN;
        end else if (scan_last) begin
          state_next = S_RESP;
        end
      end
      S_GEN:  state_next = S_RESP;
      S_RESP: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      live_count <= '0;
      hw         <= '0;
      hint       <= '0;
    end else begin
      state <= state_next;
      if (state == S_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (state == S_LOOK && map_we) begin
        live_count <= live_count - CNT_W'(1);
        if (word_idx < hint) begin
          hint <= word_idx;
        end
      end
      if (state == S_GEN) begin
        live_count <= live_count + CNT_W'(1);
        // every word below this one is full
        hint <= word_idx;
        if (CNT_W'(slot) == hw) begin
          hw <= hw + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op       <= req.operation;
          qgen     <= req.query_generation;
          slot     <= id_m1;
          word_idx <= (req.operation == OP_ALLOC) ? hint : id_word;
          res      <= res_init;
        end
      end
      S_PREP: begin
        bit_idx <= BIT_W'(CNT_W'(slot) - word_base);
      end
      S_SCAN: begin
        if (fz_found) begin
          slot      <= slot_found;
          bit_idx   <= fz_idx;
          word_hold <= map_word;
        end else if (scan_last) begin
          res.status <= ST_EXHAUSTED;
        end else begin
          word_idx <= word_next;
        end
      end
      S_LOOK: begin
        res.slot_generation <= gen_cur;
        if (op == OP_FREE) begin
          if (!used) begin
            res.status <= ST_DOUBLE_FREE;
          end
        end else begin
          res.is_allocated <= used;
          if (qgen == '0 || qgen > gen_cur) begin
            res.life <= LIFE_NEVER;
          end else if (qgen < gen_cur) begin
            res.life <= LIFE_DEPARTED;
          end else begin
            res.life <= used ? LIFE_LIVE : LIFE_DEPARTED;
          end
        end
      end
      S_GEN: begin
        res.id_out          <= 9'(CNT_W'(slot) + CNT_W'(1));
        res.slot_generation <= gen_new;
        res.is_allocated    <= 1'b1;
        res.life            <= LIFE_LIVE;
      end
      S_RESP: begin
        if (rsp_free) begin
          rsp <= rsp_load;
        end
      end
      default: ;
    endcase
  end

  `IDAG_ASSERT_RST(a_reset_idle, (rst |=> (state == S_IDLE && !rsp_valid)), "reset did not idle the block")
  `IDAG_ASSERT(a_live_range, (live_count <= hw), "live count above high-water mark")
  `IDAG_ASSERT(a_hw_range, (hw <= CNT_W'(NUM_IDS)), "high-water mark beyond pool")
  `IDAG_ASSERT(a_rsp_from_resp, ($rose(rsp_valid) |-> ($past(state) == S_RESP)), "response loaded outside response state")
  `IDAG_ASSERT(a_alloc_count, ((state == S_GEN) |=> (live_count == $past(live_count) + CNT_W'(1))), "allocate did not bump live count")
  `IDAG_ASSERT(a_write_states, ((map_we || gen_we) |-> (state == S_GEN || state == S_LOOK)), "ram write outside update states")

endmodule

// ===== sv/idag_ram.sv =====
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module idag_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/idag_first_zero.sv =====
`timescale 1ns / 1ps
// finds the lowest clear bit of a bitmap word
// no dependencies
module idag_first_zero #(
  parameter int W = 64,
  localparam int IW = $clog2(W)
) (
  input  logic [W-1:0]  word,
  output logic          found,
  output logic [IW-1:0] index
);

  logic [W-1:0] free_bits;
  logic [W-1:0] lowest;

  assign free_bits = ~word;
  // isolate the lowest set bit of the free mask
  assign lowest = free_bits & (~free_bits + W'(1));
  assign found  = |free_bits;

  // one-hot to binary
  always_comb begin
    index = '0;
    for (int k = 0; k < IW; k++) begin
      for (int i = 0; i < W; i++) begin
        if (lowest[i] && (((i >> k) & 1) != 0)) begin
          index[k] = 1'b1;
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for id_allocator_with_generation: directed table and random
// traffic, checked against typed expected rows or an in-bench slot pool predictor
// depends on idag_pkg and the id_allocator_with_generation rtl
module testbench;
  import idag_pkg::*;

  localparam int NUM_IDS        = NUM_IDS_DEF;
  localparam int RANDOM_ITEMS   = 1930;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTS     = 50;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] RX_OPEN     = 2'd0;
  localparam logic [1:0] RX_CHOPPY   = 2'd1;
  localparam logic [1:0] RX_PERIODIC = 2'd2;
  localparam logic [1:0] RX_SPARSE   = 2'd3;

  typedef struct {
    req_t cmd;
    bit   typed;
    rsp_t want;
  } step_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // predicted pool state
  logic [NUM_IDS-1:0] slot_busy = '0;
  logic [15:0]        gen_of_slot [NUM_IDS];
  int                 live_slots = 0;

  rsp_t pending_rsp [$];
  int   mismatches   = 0;
  int   items_sent   = 0;
  int   burst_left   = 0;
  int   quiet_cycles = 0;

  logic [1:0] rx_mode = RX_OPEN;
  int         rx_span = 0;
  int         rx_tick = 0;

  id_allocator_with_generation u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_IDS; i++) gen_of_slot[i] = '0;
  end

  // applies one transaction to the predicted pool and returns its response
  function automatic rsp_t predict_response(req_t r);
    rsp_t        o;
    bit          id_ok;
    int          slot;
    int          s;
    logic [15:0] g;
    o = '0;
    id_ok = (r.id_in != 0) && (r.id_in <= NUM_IDS);
    slot = id_ok ? int'(r.id_in) - 1 : 0;
    case (r.operation)
      OP_ALLOC: begin
        slot = NUM_IDS;
        for (s = NUM_IDS - 1; s >= 0; s--) if (!slot_busy[s]) slot = s;
        if (slot == NUM_IDS) begin
          o.status = ST_EXHAUSTED;
        end else begin
          g = (gen_of_slot[slot] == GEN_MAX) ? 16'd1 : gen_of_slot[slot] + 16'd1;
          gen_of_slot[slot] = g;
          slot_busy[slot] = 1'b1;
          live_slots++;
          o.id_out = 9'(slot + 1);
          o.slot_generation = g;
          o.is_allocated = 1'b1;
          o.life = LIFE_LIVE;
        end
      end
      OP_FREE: begin
        if (!id_ok) begin
          o.status = ST_INVALID;
        end else if (!slot_busy[slot]) begin
          o.status = ST_DOUBLE_FREE;
          o.slot_generation = gen_of_slot[slot];
        end else begin
          slot_busy[slot] = 1'b0;
          if (live_slots > 0) live_slots--;
          o.slot_generation = gen_of_slot[slot];
        end
      end
      OP_QUERY: begin
        if (!id_ok) begin
          o.status = ST_INVALID;
        end else begin
          g = gen_of_slot[slot];
          o.slot_generation = g;
          o.is_allocated = slot_busy[slot];
          if (r.query_generation == 0 || r.query_generation > g) o.life = LIFE_NEVER;
          else if (r.query_generation < g) o.life = LIFE_DEPARTED;
          else o.life = slot_busy[slot] ? LIFE_LIVE : LIFE_DEPARTED;
        end
      end
      default: begin
      end
    endcase
    o.live_total = 9'(live_slots);
    return o;
  endfunction

  function automatic req_t make_req(logic [1:0] op, logic [11:0] id, logic [15:0] qgen);
    req_t r;
    r.operation = op;
    r.id_in = id;
    r.query_generation = qgen;
    return r;
  endfunction

  // a live id from a random starting point, or any valid id when the pool is empty
  function automatic logic [11:0] pick_live_id();
    int origin;
    int k;
    origin = $urandom_range(0, NUM_IDS - 1);
    for (k = 0; k < NUM_IDS; k++)
      if (slot_busy[(origin + k) % NUM_IDS]) return 12'((origin + k) % NUM_IDS + 1);
    return 12'(origin + 1);
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int          pick;
    logic [15:0] g;
    r = make_req(OP_ALLOC, 12'($urandom), 16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.operation = OP_ALLOC;
    end else if (pick < 60) begin
      r.operation = OP_FREE;
      r.id_in = pick_live_id();
    end else if (pick < 80) begin
      r.operation = OP_QUERY;
      r.id_in = ($urandom_range(0, 2) != 0) ? pick_live_id() : 12'($urandom_range(1, NUM_IDS));
      g = gen_of_slot[r.id_in - 1];
      // aim the generation at the boundaries of the live/departed/never split
      case ($urandom_range(0, 4))
        0: r.query_generation = g;
        1: r.query_generation = g - 16'd1;
        2: r.query_generation = g + 16'd1;
        3: r.query_generation = '0;
        default: r.query_generation = 16'($urandom);
      endcase
    end else if (pick < 88) begin
      r.operation = OP_FREE;
      r.id_in = 12'($urandom_range(1, NUM_IDS));
    end else begin
      r.operation = 2'($urandom_range(0, 3));
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // drives one request, waits for acceptance and queues its expected response
  task automatic issue(req_t r, bit typed = 1'b0, rsp_t want = '0);
    rsp_t predicted;
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = predict_response(r);
    pending_rsp.push_back(typed ? want : predicted);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic fill_pool();
    while (live_slots < NUM_IDS) issue(make_req(OP_ALLOC, 12'($urandom), 16'($urandom)));
    repeat (2) issue(make_req(OP_ALLOC, 12'($urandom), 16'($urandom)));
    repeat (4) issue(make_req(OP_QUERY, 12'($urandom_range(1, NUM_IDS)), 16'($urandom)));
  endtask

  task automatic drain_pool();
    while (live_slots > 0) issue(make_req(OP_FREE, pick_live_id(), 16'($urandom)));
  endtask

  // receiver: ready pattern switches among open, choppy, periodic and sparse styles, each held for a random span
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= 2'($urandom_range(0, 3));
      rx_span <= $urandom_range(30, 300);
    end else begin
      rx_span <= rx_span - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_OPEN: rsp_ready <= 1'b1;
      RX_CHOPPY: rsp_ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: rsp_ready <= ((rx_tick % 6) < 2);
      RX_SPARSE: rsp_ready <= ($urandom_range(0, 7) == 0);
      default: rsp_ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch($sformatf("response with none pending: %p", rsp));
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", 16'(rsp.status), 16'(want.status));
        check_field("id_out", 16'(rsp.id_out), 16'(want.id_out));
        check_field("slot_generation", rsp.slot_generation, want.slot_generation);
        check_field("is_allocated", 16'(rsp.is_allocated), 16'(want.is_allocated));
        check_field("life", 16'(rsp.life), 16'(want.life));
        check_field("live_total", 16'(rsp.live_total), 16'(want.live_total));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** id_allocator_with_generation: FAILED **");
      $finish;
    end
  end

  initial begin
    step_row_t directed_rows [$];
    int        random_start;
    int        pick;
    int        fills;

    // typed rows follow from reset state; the rest go through the predictor
    directed_rows = '{
      '{'{OP_QUERY, 12'd0, 16'd5}, 1'b1, '{ST_INVALID, 9'd0, 16'd0, 1'b0, LIFE_NEVER, 9'd0}},
      '{'{OP_FREE, 12'd1, 16'd0}, 1'b1, '{ST_DOUBLE_FREE, 9'd0, 16'd0, 1'b0, LIFE_NEVER, 9'd0}},
      '{'{OP_ALLOC, 12'd0, 16'd0}, 1'b1, '{ST_OK, 9'd1, 16'd1, 1'b1, LIFE_LIVE, 9'd1}},
      '{'{OP_ALLOC, 12'd4095, 16'hFFFF}, 1'b1, '{ST_OK, 9'd2, 16'd1, 1'b1, LIFE_LIVE, 9'd2}},
      '{'{OP_QUERY, 12'd1, 16'd1}, 1'b1, '{ST_OK, 9'd0, 16'd1, 1'b1, LIFE_LIVE, 9'd2}},
      '{'{OP_QUERY, 12'd1, 16'd0}, 1'b1, '{ST_OK, 9'd0, 16'd1, 1'b1, LIFE_NEVER, 9'd2}},
      '{'{OP_QUERY, 12'd1, 16'hFFFF}, 1'b1, '{ST_OK, 9'd0, 16'd1, 1'b1, LIFE_NEVER, 9'd2}},
      '{'{OP_FREE, 12'd1, 16'd0}, 1'b1, '{ST_OK, 9'd0, 16'd1, 1'b0, LIFE_NEVER, 9'd1}},
      '{'{OP_QUERY, 12'd1, 16'd1}, 1'b1, '{ST_OK, 9'd0, 16'd1, 1'b0, LIFE_DEPARTED, 9'd1}},
      '{'{OP_FREE, 12'd1, 16'd0}, 1'b1, '{ST_DOUBLE_FREE, 9'd0, 16'd1, 1'b0, LIFE_NEVER, 9'd1}},
      '{'{OP_ALLOC, 12'd0, 16'd0}, 1'b1, '{ST_OK, 9'd1, 16'd2, 1'b1, LIFE_LIVE, 9'd2}},
      '{'{OP_QUERY, 12'd1, 16'd1}, 1'b1, '{ST_OK, 9'd0, 16'd2, 1'b1, LIFE_DEPARTED, 9'd2}},
      '{'{OP_FREE, 12'd257, 16'd0}, 1'b1, '{ST_INVALID, 9'd0, 16'd0, 1'b0, LIFE_NEVER, 9'd2}},
      '{'{OP_QUERY, 12'd4095, 16'hFFFF}, 1'b1, '{ST_INVALID, 9'd0, 16'd0, 1'b0, LIFE_NEVER, 9'd2}},
      '{'{OP_UNUSED, 12'd4095, 16'hFFFF}, 1'b1, '{ST_OK, 9'd0, 16'd0, 1'b0, LIFE_NEVER, 9'd2}},
      '{'{OP_QUERY, 12'd256, 16'd0}, 1'b1, '{ST_OK, 9'd0, 16'd0, 1'b0, LIFE_NEVER, 9'd2}},
      '{'{OP_FREE, 12'd256, 16'hFFFF}, 1'b1, '{ST_DOUBLE_FREE, 9'd0, 16'd0, 1'b0, LIFE_NEVER, 9'd2}},
      '{'{OP_QUERY, 12'd2, 16'd1}, 1'b0, '0},
      '{'{OP_FREE, 12'd2, 16'd0}, 1'b0, '0},
      '{'{OP_UNUSED, 12'd0, 16'd0}, 1'b0, '0},
      '{'{OP_QUERY, 12'd2, 16'd2}, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) issue(directed_rows[i].cmd, directed_rows[i].typed,
                                     directed_rows[i].want);
    hold_until_drained();

    random_start = items_sent;
    fills = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 29);
      if (pick == 0 || (fills == 0 && items_sent - random_start > RANDOM_ITEMS / 3)) begin
        fill_pool();
        fills++;
        hold_until_drained();
      end else if (pick == 1) begin
        drain_pool();
      end else if (pick == 2) begin
        hold_until_drained();
      end else begin
        repeat ($urandom_range(5, 40)) issue(random_request());
      end
    end

    hold_until_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("** id_allocator_with_generation: PASSED **");
    end else begin
      $display("** id_allocator_with_generation: FAILED **");
    end
    $finish;
  end

endmodule
